### sv/first_fit_exclusion_station_assign_defines.svh
// Assertion macros for the first-fit exclusion station assigner.
`ifndef FIRST_FIT_EXCLUSION_STATION_ASSIGN_DEFINES_SVH
`define FIRST_FIT_EXCLUSION_STATION_ASSIGN_DEFINES_SVH

// Checked only while out of reset.
`define FFESA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define FFESA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/ffesa_pkg.sv
// Shared types and codes of the first-fit exclusion station assigner.
package ffesa_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_ASSIGN = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NO_STATION = 2'd2,
        STAT_ASSIGNED   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_CLEAR,
        S_FIN
    } t_state;

endpackage

### sv/ffesa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffesa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ffesa_cell.sv
// One exclusion-pair cell of the rotating pair ring, with its match logic.
module ffesa_cell #(
    parameter int IW = 8
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_shift,
    input  logic [IW-1:0] i_new_a,
    input  logic [IW-1:0] i_new_b,
    input  logic [IW-1:0] i_prev_a,
    input  logic [IW-1:0] i_prev_b,
    input  logic [IW-1:0] i_query,
    output logic [IW-1:0] o_a,
    output logic [IW-1:0] o_b,
    output logic          o_hit,
    output logic [IW-1:0] o_other
);

    logic [IW-1:0] r_a;
    logic [IW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_new_a;
            r_b <= i_new_b;
        end else if (i_shift) begin
            r_a <= i_prev_a;
            r_b <= i_prev_b;
        end
    end

    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_hit   = (r_a == i_query) || (r_b == i_query);
    // self pair: other equals the query, which is never assigned during its scan
    assign o_other = (r_a == i_query) ? r_b : r_a;

endmodule

### sv/first_fit_exclusion_station_assign.sv
// Top level: greedy first-fit station assignment under pairwise exclusions.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_action, i_op_a, i_op_b
//  out     | out       | o_out_valid / i_out_ready  | o_status, o_station, o_opened_new,
//          |           |                            | o_stations_used
//
// Add and no-op items go through EXEC and FIN back to ready; a new assign also passes
// SCAN, DRAIN and PICK, the pair ring rotating one cell past the compare per cycle.
// Clear items and reset sweep the station table, OPERATION_IDS entries (at most 256);
// no item is taken during the sweep.
// A waiting result holds the block in its final state until the out transfer.
module first_fit_exclusion_station_assign #(
    parameter int MAX_EXCLUSIONS = 64,
    parameter int MAX_STATIONS   = 16,
    parameter int OPERATION_IDS  = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_op_a,
    input  logic [7:0] i_op_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [3:0] o_station,
    output logic       o_opened_new,
    output logic [4:0] o_stations_used
);

    import ffesa_pkg::*;

    localparam int NID = (OPERATION_IDS < 256) ? OPERATION_IDS : 256;
    localparam int IW  = $clog2(NID);
    localparam int SW  = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CW  = $clog2(MAX_STATIONS + 1);
    localparam int EW  = $clog2(MAX_EXCLUSIONS + 1);
    localparam int EIW = (MAX_EXCLUSIONS > 1) ? $clog2(MAX_EXCLUSIONS) : 1;
    localparam int MW  = SW + 1;

    t_state                  r_state, n_state;
    t_action                 r_action, n_action;
    logic [IW-1:0]           r_a, n_a;
    logic [IW-1:0]           r_b, n_b;
    logic [EW-1:0]           r_excl_count, n_excl_count;
    logic [CW-1:0]           r_st_count, n_st_count;
    logic [EIW-1:0]          r_pos, n_pos;
    logic                    r_look, n_look;
    logic [MAX_STATIONS-1:0] r_blocked, n_blocked;
    logic [IW-1:0]           r_clr_idx, n_clr_idx;
    t_status                 r_res_status, n_res_status;
    logic [3:0]              r_res_station, n_res_station;
    logic                    r_res_opened, n_res_opened;
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [3:0]              r_out_station;
    logic                    r_out_opened;
    logic [4:0]              r_out_used;

    logic [IW-1:0] w_mod_tab [256];
    logic [IW-1:0] w_in_a;
    logic [IW-1:0] w_in_b;

    logic                      w_add_wr;
    logic                      w_shift;
    logic [MAX_EXCLUSIONS-1:0] w_load;
    logic [IW-1:0]             w_cell_a [MAX_EXCLUSIONS];
    logic [IW-1:0]             w_cell_b [MAX_EXCLUSIONS];
    logic                      w_exit_hit;
    logic [IW-1:0]             w_exit_other;
    logic                      w_scan_valid;

    logic          w_ram_we;
    logic [IW-1:0] w_ram_waddr;
    logic [MW-1:0] w_ram_wdata;
    logic [IW-1:0] w_ram_raddr;
    logic [MW-1:0] w_rdata;
    logic          w_rd_valid;
    logic [SW-1:0] w_rd_station;

    logic          w_found;
    logic [SW-1:0] w_first;
    logic          w_out_load;

    // id reduction modulo the id space
    for (genvar g = 0; g < 256; g++) begin : g_mod
        localparam int ModVal = g % NID;
        assign w_mod_tab[g] = IW'(ModVal);
    end

    assign w_in_a = w_mod_tab[i_op_a];
    assign w_in_b = w_mod_tab[i_op_b];

    // pair ring
    assign w_shift = (r_state == S_SCAN);

    for (genvar k = 0; k < MAX_EXCLUSIONS; k++) begin : g_cell
        localparam int Prev = (k == 0) ? MAX_EXCLUSIONS - 1 : k - 1;
        assign w_load[k] = w_add_wr && (r_excl_count[EIW-1:0] == EIW'(k));
        if (k == MAX_EXCLUSIONS - 1) begin : g_exit
            ffesa_cell #(.IW(IW)) u_cell (
                .i_clk    (i_clk),
                .i_load   (w_load[k]),
                .i_shift  (w_shift),
                .i_new_a  (r_a),
                .i_new_b  (r_b),
                .i_prev_a (w_cell_a[Prev]),
                .i_prev_b (w_cell_b[Prev]),
                .i_query  (r_a),
                .o_a      (w_cell_a[k]),
                .o_b      (w_cell_b[k]),
                .o_hit    (w_exit_hit),
                .o_other  (w_exit_other)
            );
        end else begin : g_mid
            ffesa_cell #(.IW(IW)) u_cell (
                .i_clk    (i_clk),
                .i_load   (w_load[k]),
                .i_shift  (w_shift),
                .i_new_a  (r_a),
                .i_new_b  (r_b),
                .i_prev_a (w_cell_a[Prev]),
                .i_prev_b (w_cell_b[Prev]),
                .i_query  (r_a),
                .o_a      (w_cell_a[k]),
                .o_b      (w_cell_b[k]),
                .o_hit    (),
                .o_other  ()
            );
        end
    end

    // exit cell holds original entry r_pos
    assign w_scan_valid = (EW'(r_pos) < r_excl_count);

    // station of each operation: {valid, station}
    ffesa_ram #(.WIDTH(MW), .DEPTH(NID)) u_station_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_valid   = w_rdata[MW-1];
    assign w_rd_station = w_rdata[SW-1:0];

    // first open unblocked station
    always_comb begin
        w_found = 1'b0;
        w_first = '0;
        for (int s = 0; s < MAX_STATIONS; s++) begin
            if (!w_found && !r_blocked[s] && (CW'(s) < r_st_count)) begin
                w_found = 1'b1;
                w_first = SW'(s);
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_a           = r_a;
        n_b           = r_b;
        n_excl_count  = r_excl_count;
        n_st_count    = r_st_count;
        n_pos         = r_pos;
        n_look        = r_look;
        n_blocked     = r_blocked;
        n_clr_idx     = r_clr_idx;
        n_res_status  = r_res_status;
        n_res_station = r_res_station;
        n_res_opened  = r_res_opened;
        o_in_ready    = 1'b0;
        w_add_wr      = 1'b0;
        w_out_load    = 1'b0;
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_a;
        w_ram_wdata   = '0;
        w_ram_raddr   = r_a;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_idx;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(NID - 1)) begin
                    n_clr_idx = '0;
                    n_state   = (r_state == S_INIT) ? S_IDLE : S_FIN;
                end
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                w_ram_raddr = w_in_a;
                if (i_in_valid) begin
                    n_action = t_action'(i_action);
                    n_a      = w_in_a;
                    n_b      = w_in_b;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status  = STAT_OK;
                n_res_station = '0;
                n_res_opened  = 1'b0;
                n_state       = S_FIN;
                unique case (r_action)
                    ACT_ADD: begin
                        if (r_excl_count == EW'(MAX_EXCLUSIONS)) begin
                            n_res_status = STAT_FULL;
                        end else begin
                            w_add_wr     = 1'b1;
                            n_excl_count = r_excl_count + 1'b1;
                        end
                    end
                    ACT_ASSIGN: begin
                        if (w_rd_valid) begin
                            n_res_status  = STAT_ASSIGNED;
                            n_res_station = 4'(w_rd_station);
                        end else begin
                            n_blocked = '0;
                            n_pos     = EIW'(MAX_EXCLUSIONS - 1);
                            n_look    = 1'b0;
                            n_state   = S_SCAN;
                        end
                    end
                    ACT_CLEAR: begin
                        n_excl_count = '0;
                        n_st_count   = '0;
                        n_clr_idx    = '0;
                        n_state      = S_CLEAR;
                    end
                    ACT_NOP: begin
                    end
                endcase
            end
            S_SCAN: begin
                w_ram_raddr = w_exit_other;
                n_look      = w_exit_hit && w_scan_valid;
                if (r_look && w_rd_valid && (w_rd_station < MAX_STATIONS)) begin
                    n_blocked[w_rd_station] = 1'b1;
                end
                n_pos = r_pos - 1'b1;
                if (r_pos == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_look && w_rd_valid && (w_rd_station < MAX_STATIONS)) begin
                    n_blocked[w_rd_station] = 1'b1;
                end
                n_look  = 1'b0;
                n_state = S_PICK;
            end
            S_PICK: begin
                n_state = S_FIN;
                if (w_found) begin
                    w_ram_we      = 1'b1;
                    w_ram_wdata   = {1'b1, w_first};
                    n_res_station = 4'(w_first);
                end else if (r_st_count < CW'(MAX_STATIONS)) begin
                    w_ram_we      = 1'b1;
                    w_ram_wdata   = {1'b1, SW'(r_st_count)};
                    n_res_station = 4'(r_st_count);
                    n_res_opened  = 1'b1;
                    n_st_count    = r_st_count + 1'b1;
                end else begin
                    n_res_status = STAT_NO_STATION;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_clr_idx    <= '0;
            r_excl_count <= '0;
            r_st_count   <= '0;
            r_look       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_excl_count <= n_excl_count;
            r_st_count   <= n_st_count;
            r_look       <= n_look;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_a           <= n_a;
        r_b           <= n_b;
        r_pos         <= n_pos;
        r_blocked     <= n_blocked;
        r_res_status  <= n_res_status;
        r_res_station <= n_res_station;
        r_res_opened  <= n_res_opened;
        if (w_out_load) begin
            r_out_status  <= r_res_status;
            r_out_station <= r_res_station;
            r_out_opened  <= r_res_opened;
            r_out_used    <= 5'(r_st_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_station       = r_out_station;
    assign o_opened_new    = r_out_opened;
    assign o_stations_used = r_out_used;

endmodule

### sv/ffesa_checker.sv
// Port-level checker for the first-fit exclusion station assigner, with its bind.
`include "first_fit_exclusion_station_assign_defines.svh"

module ffesa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [3:0] o_station,
    input logic       o_opened_new,
    input logic [4:0] o_stations_used
);

    import ffesa_pkg::*;

    logic        w_held;
    logic [11:0] w_result;
    logic        w_opened;
    logic        w_ok;
    logic        w_new_last;
    logic        w_failed;

    assign w_held     = o_out_valid && !i_out_ready;
    assign w_result   = {o_status, o_station, o_opened_new, o_stations_used};
    assign w_opened   = o_out_valid && o_opened_new;
    assign w_ok       = (o_status == STAT_OK);
    assign w_new_last = (o_station == 4'(o_stations_used - 5'd1));
    assign w_failed   = o_out_valid && (o_status == STAT_FULL || o_status == STAT_NO_STATION);

    `FFESA_ASSERT_ALWAYS(a_reset_empties_out, !i_rst_n |=> !o_out_valid, "out valid after reset")
    `FFESA_ASSERT(a_one_item, i_in_valid && o_in_ready |=> !o_in_ready, "item taken while busy")
    `FFESA_ASSERT(a_out_hold, w_held |=> o_out_valid && $stable(w_result), "result dropped")
    `FFESA_ASSERT(a_new_is_last, w_opened |-> w_ok && w_new_last, "new station is not the last one")
    `FFESA_ASSERT(a_fail_zero, w_failed |-> o_station == 4'd0 && !o_opened_new, "failed item station")

endmodule

bind first_fit_exclusion_station_assign ffesa_checker u_ffesa_checker (.*);
